FILE: src/sarsa_pkg.sv
// Shared types and constants for the SARSA agent step block.
package sarsa_pkg;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_SCANW,
		ST_CHOOSE,
		ST_LOOK,
		ST_MUL1,
		ST_OLD,
		ST_MUL2,
		ST_WRITE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic clr_step;
		logic take;
		logic scan_rd;
		logic scan_cmp;
		logic choose;
		logic look_rd;
		logic mul1;
		logic old_rd;
		logic mul2;
		logic wr;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic scan_last;
	} sts_t;

	localparam logic [0:0] REG_LEARN_RATE = 1'b0;
	localparam logic [0:0] REG_DISCOUNT   = 1'b1;
	localparam logic [15:0] LEARN_RATE_RESET = 16'd19661;
	localparam logic [15:0] DISCOUNT_RESET   = 16'd45875;

endpackage

FILE: src/sarsa_tabular_agent_step.sv
// Top level of the SARSA tabular agent step block.
// Each transaction scans its Q-table row serially on one read port; a new
// input is accepted only after the result of the last one has been taken.
// After reset a clearing pass sets every table entry to 10.0 (to the largest
// value when VALUE_BITS is 20 or less); no input is accepted until it ends.
module sarsa_tabular_agent_step #(
	parameter int NUM_DIMS   = 4,
	parameter int LEVELS     = 4,
	parameter int VALUE_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] performance,
	input  logic [6:0]         greedy_threshold,
	input  logic [6:0]         explore_draw,
	input  logic [3:0]         random_pick,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [3:0]         chosen_action,
	output logic [7:0]         new_position,
	output logic               was_greedy,
	output logic signed [15:0] reward_out
);
	sarsa_pkg::cmd_t cmd;
	sarsa_pkg::sts_t sts;

	sarsa_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
	);

	sarsa_dp #(.NUM_DIMS(NUM_DIMS), .LEVELS(LEVELS), .VALUE_BITS(VALUE_BITS)) u_dp (
		.clk, .arst_n, .cmd, .sts, .cfg_we, .cfg_index, .cfg_wdata,
		.performance, .greedy_threshold, .explore_draw, .random_pick,
		.chosen_action, .new_position, .was_greedy, .reward_out
	);
endmodule

FILE: src/sarsa_ctrl.sv
// Controller state machine for the SARSA agent step block.
module sarsa_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  sarsa_pkg::sts_t  sts,
	output sarsa_pkg::cmd_t  cmd
);
	sarsa_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= sarsa_pkg::ST_CLEAR;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			sarsa_pkg::ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done) state_d = sarsa_pkg::ST_IDLE;
			end
			sarsa_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d = sarsa_pkg::ST_SCAN;
				end
			end
			sarsa_pkg::ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				state_d = sarsa_pkg::ST_SCANW;
			end
			sarsa_pkg::ST_SCANW: begin
				cmd.scan_cmp = 1'b1;
				if (sts.scan_last) state_d = sarsa_pkg::ST_CHOOSE;
				else begin
					cmd.scan_rd = 1'b1;
				end
			end
			sarsa_pkg::ST_CHOOSE: begin
				cmd.choose = 1'b1;
				state_d = sarsa_pkg::ST_LOOK;
			end
			sarsa_pkg::ST_LOOK: begin
				cmd.look_rd = 1'b1;
				state_d = sarsa_pkg::ST_MUL1;
			end
			sarsa_pkg::ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d = sarsa_pkg::ST_OLD;
			end
			sarsa_pkg::ST_OLD: begin
				cmd.old_rd = 1'b1;
				state_d = sarsa_pkg::ST_MUL2;
			end
			sarsa_pkg::ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d = sarsa_pkg::ST_WRITE;
			end
			sarsa_pkg::ST_WRITE: begin
				cmd.wr = 1'b1;
				cmd.commit = 1'b1;
				state_d = sarsa_pkg::ST_OUT;
			end
			sarsa_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = sarsa_pkg::ST_IDLE;
			end
			default: state_d = sarsa_pkg::ST_CLEAR;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("accept during result hold");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr |=> out_valid) else $error("no result after write");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid) else $error("result dropped");
endmodule

FILE: src/sarsa_dp.sv
// Datapath for the SARSA agent step: Q table, scan, choice and update.
module sarsa_dp #(
	parameter int NUM_DIMS   = 4,
	parameter int LEVELS     = 4,
	parameter int VALUE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sarsa_pkg::cmd_t       cmd,
	output sarsa_pkg::sts_t       sts,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [15:0]           cfg_wdata,
	input  logic signed [31:0]    performance,
	input  logic [6:0]            greedy_threshold,
	input  logic [6:0]            explore_draw,
	input  logic [3:0]            random_pick,
	output logic [3:0]            chosen_action,
	output logic [7:0]            new_position,
	output logic                  was_greedy,
	output logic signed [15:0]    reward_out
);
	localparam int NS = LEVELS ** NUM_DIMS;
	localparam int NA = 1 + 2 * NUM_DIMS;
	localparam int DEPTH = NS * NA;
	localparam int AW = $clog2(DEPTH);
	localparam int PW = (NS > 1) ? $clog2(NS) : 1;
	localparam int DW = $clog2(LEVELS);
	localparam int VB = VALUE_BITS;
	localparam int XB = VB + 18;
	localparam logic signed [VB-1:0] QMAX = {1'b0, {(VB-1){1'b1}}};
	localparam logic signed [VB-1:0] QMIN = {1'b1, {(VB-1){1'b0}}};
	localparam logic signed [VB-1:0] QINIT = (VB > 20) ?
		VB'(64'sd655360) : QMAX;

	logic signed [VB-1:0] mem [DEPTH];
	logic signed [VB-1:0] rd_q;
	logic [AW-1:0] rd_addr, wr_addr, clr_q;
	logic mem_we;
	logic signed [VB-1:0] wr_data;

	logic [15:0] learn_rate_q, discount_q;
	logic [PW-1:0] pos_q, prev_pos_q;
	logic [DW-1:0] dig_q [NUM_DIMS];
	logic [3:0] prev_act_q;
	logic signed [15:0] prev_rew_q;
	logic signed [31:0] prev_perf_q;
	logic signed [31:0] perf_q;
	logic [6:0] thr_q, draw_q;
	logic [3:0] rem_q;
	logic [6:0] dvs_q;
	logic [2:0] rem_n_q;
	logic [NA-1:0] allowed;
	logic [3:0] scan_a_q, cmp_a_q, best_q, act_q;
	logic signed [VB-1:0] bestv_q;
	logic greedy_q;
	logic signed [XB-1:0] sample_q, diff_q;
	logic signed [VB-1:0] oldv_q;
	logic signed [XB-1:0] upd_q;
	logic [PW-1:0] newpos_q, step_pos;
	logic signed [15:0] whole_q;

	always_ff @(posedge clk) begin
		if (mem_we) mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	always_comb begin
		allowed[0] = 1'b1;
		for (int i = 0; i < NUM_DIMS; i++) begin
			allowed[2*i+1] = (dig_q[i] != DW'(LEVELS - 1));
			allowed[2*i+2] = (dig_q[i] != '0);
		end
	end

	always_comb begin
		step_pos = pos_q;
		for (int i = 0; i < NUM_DIMS; i++) begin
			if (act_q == 4'(2*i+1)) step_pos = pos_q + PW'(LEVELS ** i);
			else if (act_q == 4'(2*i+2)) step_pos = pos_q - PW'(LEVELS ** i);
		end
	end

	function automatic logic [AW-1:0] qaddr(input logic [PW-1:0] p, input logic [3:0] a);
		qaddr = AW'(32'(p) * NA + 32'(a));
	endfunction

	always_comb begin
		rd_addr = qaddr(pos_q, scan_a_q);
		if (cmd.look_rd) rd_addr = qaddr(pos_q, act_q);
		if (cmd.old_rd) rd_addr = qaddr(prev_pos_q, prev_act_q);
		mem_we = cmd.clr_step | cmd.wr;
		wr_addr = cmd.clr_step ? clr_q : qaddr(prev_pos_q, prev_act_q);
		if (upd_q > XB'(QMAX)) wr_data = QMAX;
		else if (upd_q < XB'(QMIN)) wr_data = QMIN;
		else wr_data = VB'(upd_q);
		wr_data = cmd.clr_step ? QINIT : wr_data;
	end

	assign sts.clr_done = (32'(clr_q) == DEPTH - 1);
	assign sts.scan_last = (32'(cmp_a_q) == NA - 1);

	logic [3:0] cnt, sel;
	logic signed [32:0] dlt;
	logic signed [32:0] wq;
	always_comb begin
		cnt = '0;
		for (int a = 0; a < NA; a++) cnt = cnt + 4'(allowed[a]);
		sel = '0;
		for (int a = NA - 1; a >= 0; a--) begin
			logic [3:0] c;
			c = '0;
			for (int b = 0; b < a; b++) c = c + 4'(allowed[b]);
			if (allowed[a] && c == rem_q) sel = 4'(a);
		end
		dlt = 33'(perf_q) - 33'(prev_perf_q);
		wq = dlt / 33'sd65536;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			learn_rate_q <= sarsa_pkg::LEARN_RATE_RESET;
			discount_q <= sarsa_pkg::DISCOUNT_RESET;
			pos_q <= '0;
			for (int i = 0; i < NUM_DIMS; i++) dig_q[i] <= '0;
			prev_pos_q <= '0;
			prev_act_q <= '0;
			prev_rew_q <= '0;
			prev_perf_q <= '0;
		end else begin
			if (cmd.clr_step) clr_q <= clr_q + 1'b1;
			if (cfg_we && cfg_index == sarsa_pkg::REG_LEARN_RATE) learn_rate_q <= cfg_wdata;
			if (cfg_we && cfg_index == sarsa_pkg::REG_DISCOUNT) discount_q <= cfg_wdata;
			if (cmd.commit) begin
				pos_q <= newpos_q;
				for (int i = 0; i < NUM_DIMS; i++) begin
					if (act_q == 4'(2*i+1)) dig_q[i] <= dig_q[i] + 1'b1;
					else if (act_q == 4'(2*i+2)) dig_q[i] <= dig_q[i] - 1'b1;
				end
				prev_pos_q <= pos_q;
				prev_act_q <= act_q;
				prev_rew_q <= whole_q;
				prev_perf_q <= perf_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			perf_q <= performance;
			thr_q <= greedy_threshold;
			draw_q <= explore_draw;
			rem_q <= random_pick;
			dvs_q <= {cnt, 3'b000};
			rem_n_q <= 3'd4;
			scan_a_q <= '0;
		end
		// pick mod count, one restoring step per scan cycle
		if (rem_n_q != '0 && (cmd.scan_rd || cmd.scan_cmp)) begin
			if ({3'b000, rem_q} >= dvs_q) rem_q <= rem_q - dvs_q[3:0];
			dvs_q <= dvs_q >> 1;
			rem_n_q <= rem_n_q - 1'b1;
		end
		if (cmd.scan_rd) begin
			cmp_a_q <= scan_a_q;
			scan_a_q <= scan_a_q + 1'b1;
		end
		if (cmd.scan_cmp) begin
			if (cmp_a_q == '0 || (allowed[cmp_a_q] && rd_q > bestv_q)) begin
				bestv_q <= rd_q;
				best_q <= cmp_a_q;
			end
		end
		if (cmd.choose) begin
			greedy_q <= draw_q < thr_q;
			act_q <= (draw_q < thr_q) ? best_q : sel;
			if (wq > 33'sd32767) whole_q <= 16'sh7fff;
			else if (wq < -33'sd32768) whole_q <= 16'sh8000;
			else whole_q <= 16'(wq);
		end
		if (cmd.look_rd) newpos_q <= step_pos;
		if (cmd.mul1)
			sample_q <= (XB'(prev_rew_q) <<< 16) +
				XB'((XB'(rd_q) * $signed({1'b0, discount_q})) >>> 16);
		if (cmd.old_rd) oldv_q <= VB'(0);
		if (cmd.mul2) begin
			oldv_q <= rd_q;
			diff_q <= sample_q - XB'(rd_q);
		end
	end

	assign upd_q = XB'(oldv_q) + XB'((diff_q * $signed({1'b0, learn_rate_q})) >>> 16);

	assign chosen_action = act_q;
	assign new_position = 8'(newpos_q);
	assign was_greedy = greedy_q;
	assign reward_out = prev_rew_q;
endmodule
